// ----- rtl/etic_pkg.sv -----
// etic_pkg: shared constants, control word type and microprogram table
// for the escape-time iteration counter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package etic_pkg;

  localparam int FRACTION_BITS = 28;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 8;
  localparam int STEP_W        = 3;

  localparam logic signed [DATA_W-1:0] THRESHOLD =
    DATA_W'(64'd2 << FRACTION_BITS);

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_XX   = 2'd1,
    DST_YY   = 2'd2,
    DST_XY   = 2'd3
  } dst_t;

  typedef enum logic [1:0] {
    BR_SEQ  = 2'd0,
    BR_GO   = 2'd1,
    BR_EMIT = 2'd2
  } branch_t;

  typedef struct packed {
    logic              a_sel_y;
    logic              b_sel_y;
    dst_t              dst;
    logic              upd;
    branch_t           branch;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  localparam logic [STEP_W-1:0] STEP_MUL_XX = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_YY = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_XY = 3'd2;
  localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;

  function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{a_sel_y: 1'b0, b_sel_y: 1'b0, dst: DST_NONE, upd: 1'b0,
          branch: BR_EMIT, target: STEP_MUL_XX};
    unique case (step)
      STEP_MUL_XX: begin
        w.dst    = DST_XX;
        w.branch = BR_SEQ;
      end
      STEP_MUL_YY: begin
        w.a_sel_y = 1'b1;
        w.b_sel_y = 1'b1;
        w.dst     = DST_YY;
        w.branch  = BR_SEQ;
      end
      STEP_MUL_XY: begin
        w.b_sel_y = 1'b1;
        w.dst     = DST_XY;
        w.branch  = BR_SEQ;
      end
      STEP_UPDATE: begin
        w.upd    = 1'b1;
        w.branch = BR_GO;
        w.target = STEP_MUL_XX;
      end
      default: begin
        w.branch = BR_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/escape_time_iteration_counter_top.sv -----
// escape-time iteration counter: microcoded sequencer over one shared
// 32x32 multiplier; depends on etic_pkg
// sequence: each iteration runs the steps MUL_XX, MUL_YY, MUL_XY and UPDATE,
// then either the next iteration or an EMIT step that waits for a free output register
// throughput: one item at a time; a new point is taken only once the last result is emitted
// reset: synchronous active-low rst_n clears control state, limit to 255
`timescale 1ns / 1ps
`default_nettype none

module escape_time_iteration_counter_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [etic_pkg::COUNT_W-1:0]      cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  signed [etic_pkg::DATA_W-1:0] in_point_real,
  input  wire  signed [etic_pkg::DATA_W-1:0] in_point_imag,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [etic_pkg::COUNT_W-1:0]      out_iteration_count,
  output logic                              out_hit_limit
);
  import etic_pkg::*;

  logic [COUNT_W-1:0]        limit_r;
  logic                      busy_r;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic signed [DATA_W-1:0]  cx_r, cy_r, x_r, y_r, xx_r, yy_r, xy_r;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic                      out_valid_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_hit_r;

  ctrl_word_t                cw;
  logic signed [DATA_W-1:0]  op_a, op_b, mul_res;
  logic signed [2*DATA_W-1:0] prod, prod_sh;
  logic signed [DATA_W-1:0]  mag, x_nxt, y_nxt;
  logic                      go;
  logic                      out_free;
  logic                      in_fire;

  assign cfg_ready           = 1'b1;
  assign in_ready            = ~busy_r;
  assign in_fire             = in_valid & in_ready;
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_hit_limit       = out_hit_r;
  assign out_free            = ~out_valid_r | out_ready;

  assign cw = rom_word(step_r);

  // shared multiplier
  assign op_a    = cw.a_sel_y ? y_r : x_r;
  assign op_b    = cw.b_sel_y ? y_r : x_r;
  assign prod    = op_a * op_b;
  assign prod_sh = prod >>> FRACTION_BITS;
  assign mul_res = prod_sh[DATA_W-1:0];

  // iteration update
  assign mag       = xx_r + yy_r;
  assign y_nxt     = xy_r + xy_r + cy_r;
  assign x_nxt     = xx_r - yy_r + cx_r;
  assign count_nxt = count_r + COUNT_W'(1);
  assign go        = (mag <= THRESHOLD) && (count_nxt < limit_r);

  always_comb begin
    step_nxt = step_r;
    unique case (cw.branch)
      BR_SEQ:  step_nxt = step_r + STEP_W'(1);
      BR_GO:   step_nxt = go ? cw.target : STEP_EMIT;
      BR_EMIT: step_nxt = STEP_MUL_XX;
      default: step_nxt = STEP_MUL_XX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= COUNT_W'(255);
      busy_r      <= 1'b0;
      step_r      <= STEP_MUL_XX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (busy_r && cw.branch == BR_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        busy_r <= 1'b1;
        step_r <= STEP_MUL_XX;
      end else if (busy_r) begin
        if (cw.branch == BR_EMIT) begin
          if (out_free) begin
            busy_r <= 1'b0;
            step_r <= step_nxt;
          end
        end else begin
          step_r <= step_nxt;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx_r    <= in_point_real;
      cy_r    <= in_point_imag;
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
    end else if (busy_r) begin
      unique case (cw.dst)
        DST_XX:   xx_r <= mul_res;
        DST_YY:   yy_r <= mul_res;
        DST_XY:   xy_r <= mul_res;
        DST_NONE: ;
        default:  ;
      endcase
      if (cw.upd) begin
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        count_r <= count_nxt;
      end
      if (cw.branch == BR_EMIT && out_free) begin
        out_count_r <= count_r;
        out_hit_r   <= (count_r == limit_r);
      end
    end
  end

endmodule

`default_nettype wire
